/* rtl/ealu_pkg.sv */
// Shared types and constants for the eight-bit ALU with flags.
// Holds the operation codes, flag bit positions and the pipeline stage records.
// No dependencies.
package ealu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_SWAP  = 5'd10,
        OP_SLA   = 5'd11,
        OP_SRA   = 5'd12,
        OP_SRL   = 5'd13,
        OP_RLC   = 5'd14,
        OP_RRC   = 5'd15,
        OP_RL    = 5'd16,
        OP_RR    = 5'd17,
        OP_BIT   = 5'd18,
        OP_SET   = 5'd19,
        OP_RES   = 5'd20,
        OP_DAA   = 5'd21,
        OP_ADD16 = 5'd22
    } op_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Adder results produced in the first stage.
    typedef struct packed {
        logic [8:0] sum9;   // byte add, or byte subtract with borrow in bit 8
        logic       half;   // carry or borrow out of the low nibble
        logic [8:0] wlo;    // low byte of the word add with its carry
    } arith_t;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] bit_index;
        logic [3:0] flags;
        logic [7:0] wa_hi;
        logic [7:0] wb_hi;
        arith_t     arith;
    } s1_t;

    typedef struct packed {
        logic [7:0]  res;
        logic [15:0] wide;
        logic [7:0]  zbyte;
        logic        z_from_byte;
        logic        z_fixed;
        logic        n;
        logic        h;
        logic        c;
    } s2_t;

endpackage

/* rtl/ealu_arith.sv */
// Adder front end of the ALU: byte add/subtract with carry and nibble carry,
// and the low byte of the word add. Uses ealu_pkg.
module ealu_arith
    import ealu_pkg::*;
(
    input  logic [4:0] opcode,
    input  logic [7:0] value_a,
    input  logic [7:0] value_b,
    input  logic       carry_in,
    input  logic [7:0] wa_lo,
    input  logic [7:0] wb_lo,
    output arith_t     arith
);

    logic       use_carry;
    logic       is_sub;
    logic [4:0] nib;

    assign use_carry = (opcode == OP_ADC || opcode == OP_SBC) ? carry_in : 1'b0;
    assign is_sub    = (opcode == OP_SUB || opcode == OP_SBC || opcode == OP_CP);

    always_comb
    begin
        if (is_sub)
        begin
            // Bit 8 goes high whenever the true difference is negative.
            arith.sum9 = {1'b0, value_a} - {1'b0, value_b} - {8'd0, use_carry};
            nib        = {1'b0, value_a[3:0]} - {1'b0, value_b[3:0]} - {4'd0, use_carry};
        end
        else
        begin
            arith.sum9 = {1'b0, value_a} + {1'b0, value_b} + {8'd0, use_carry};
            nib        = {1'b0, value_a[3:0]} + {1'b0, value_b[3:0]} + {4'd0, use_carry};
        end
        arith.half = nib[4];
        arith.wlo  = {1'b0, wa_lo} + {1'b0, wb_lo};
    end

endmodule

/* rtl/eight_bit_alu_with_flags_core.sv */
// Top level of the eight-bit ALU with flags: a three-stage pipeline.
// Uses ealu_pkg and ealu_arith.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | opcode, value_a, value_b, bit_index,
//          |                       | wide_a, wide_b, flags_in
//  out     | out_valid / out_stall | result, wide_result, flags_out
//
// One item may enter each cycle while in_stall is low. Stage one does the byte
// and low word adds, stage two selects the byte result, the upper word add and
// decimal adjust, stage three builds the flags. Reset empties the pipeline. A
// stall at the output holds stage three, and each earlier stage moves only into
// an empty or moving slot.
module eight_bit_alu_with_flags_core
    import ealu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  opcode,
    input  logic [7:0]  value_a,
    input  logic [7:0]  value_b,
    input  logic [2:0]  bit_index,
    input  logic [15:0] wide_a,
    input  logic [15:0] wide_b,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result,
    output logic [15:0] wide_result,
    output logic [3:0]  flags_out
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic [7:0]  result_reg, result_next;
    logic [15:0] wide_reg, wide_next;
    logic [3:0]  flags_reg, flags_next;

    arith_t arith;

    logic [8:0] hi9;
    logic [4:0] hnib;
    logic       daa_up;
    logic       daa_lo;
    logic [7:0] daa_adj;
    logic [7:0] daa_res;
    logic       daa_c;
    logic [7:0] mask;

    // A stage may load when it is empty or its contents move on.
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage one.
    ealu_arith u_arith (
        .opcode   (opcode),
        .value_a  (value_a),
        .value_b  (value_b),
        .carry_in (flags_in[FLAG_C]),
        .wa_lo    (wide_a[7:0]),
        .wb_lo    (wide_b[7:0]),
        .arith    (arith)
    );

    always_comb
    begin
        s1_next.op        = opcode;
        s1_next.a         = value_a;
        s1_next.b         = value_b;
        s1_next.bit_index = bit_index;
        s1_next.flags     = flags_in;
        s1_next.wa_hi     = wide_a[15:8];
        s1_next.wb_hi     = wide_b[15:8];
        s1_next.arith     = arith;
    end

    // Stage two.
    always_comb
    begin
        hi9  = {1'b0, s1_reg.wa_hi} + {1'b0, s1_reg.wb_hi} + {8'd0, s1_reg.arith.wlo[8]};
        hnib = {1'b0, s1_reg.wa_hi[3:0]} + {1'b0, s1_reg.wb_hi[3:0]}
             + {4'd0, s1_reg.arith.wlo[8]};

        mask = 8'd1 << s1_reg.bit_index;

        // Decimal adjust: one offset, added after addition, taken off after subtraction.
        if (s1_reg.flags[FLAG_N])
        begin
            daa_up  = s1_reg.flags[FLAG_C];
            daa_lo  = s1_reg.flags[FLAG_H];
        end
        else
        begin
            daa_up  = s1_reg.flags[FLAG_C] || (s1_reg.a > 8'h99);
            daa_lo  = s1_reg.flags[FLAG_H] || (s1_reg.a[3:0] > 4'h9);
        end
        daa_adj = (daa_up ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);
        daa_res = s1_reg.flags[FLAG_N] ? (s1_reg.a - daa_adj) : (s1_reg.a + daa_adj);
        daa_c   = daa_up;

        s2_next.res         = s1_reg.a;
        s2_next.wide        = 16'd0;
        s2_next.zbyte       = s1_reg.a;
        s2_next.z_from_byte = 1'b0;
        s2_next.z_fixed     = s1_reg.flags[FLAG_Z];
        s2_next.n           = s1_reg.flags[FLAG_N];
        s2_next.h           = s1_reg.flags[FLAG_H];
        s2_next.c           = s1_reg.flags[FLAG_C];

        case (s1_reg.op)
            OP_ADD, OP_ADC:
            begin
                s2_next.res = s1_reg.arith.sum9[7:0];
                s2_next.n   = 1'b0;
                s2_next.h   = s1_reg.arith.half;
                s2_next.c   = s1_reg.arith.sum9[8];
            end
            OP_SUB, OP_SBC:
            begin
                s2_next.res = s1_reg.arith.sum9[7:0];
                s2_next.n   = 1'b1;
                s2_next.h   = s1_reg.arith.half;
                s2_next.c   = s1_reg.arith.sum9[8];
            end
            OP_CP:
            begin
                s2_next.n   = 1'b1;
                s2_next.h   = s1_reg.arith.half;
                s2_next.c   = s1_reg.arith.sum9[8];
            end
            OP_AND:
            begin
                s2_next.res = s1_reg.a & s1_reg.b;
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b1;
                s2_next.c   = 1'b0;
            end
            OP_OR:
            begin
                s2_next.res = s1_reg.a | s1_reg.b;
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = 1'b0;
            end
            OP_XOR:
            begin
                s2_next.res = s1_reg.a ^ s1_reg.b;
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = 1'b0;
            end
            OP_INC:
            begin
                s2_next.res = s1_reg.a + 8'd1;
                s2_next.n   = 1'b0;
                s2_next.h   = (s1_reg.a[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                s2_next.res = s1_reg.a - 8'd1;
                s2_next.n   = 1'b1;
                s2_next.h   = (s1_reg.a[3:0] == 4'h0);
            end
            OP_SWAP:
            begin
                s2_next.res = {s1_reg.a[3:0], s1_reg.a[7:4]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = 1'b0;
            end
            OP_SLA:
            begin
                s2_next.res = {s1_reg.a[6:0], 1'b0};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[7];
            end
            OP_SRA:
            begin
                s2_next.res = {s1_reg.a[7], s1_reg.a[7:1]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[0];
            end
            OP_SRL:
            begin
                s2_next.res = {1'b0, s1_reg.a[7:1]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[0];
            end
            OP_RLC:
            begin
                s2_next.res = {s1_reg.a[6:0], s1_reg.a[7]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[7];
            end
            OP_RRC:
            begin
                s2_next.res = {s1_reg.a[0], s1_reg.a[7:1]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[0];
            end
            OP_RL:
            begin
                s2_next.res = {s1_reg.a[6:0], s1_reg.flags[FLAG_C]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[7];
            end
            OP_RR:
            begin
                s2_next.res = {s1_reg.flags[FLAG_C], s1_reg.a[7:1]};
                s2_next.n   = 1'b0;
                s2_next.h   = 1'b0;
                s2_next.c   = s1_reg.a[0];
            end
            OP_BIT:
            begin
                s2_next.z_fixed = ((s1_reg.a & mask) == 8'd0);
                s2_next.n       = 1'b0;
                s2_next.h       = 1'b1;
            end
            OP_SET:
            begin
                s2_next.res = s1_reg.a | mask;
            end
            OP_RES:
            begin
                s2_next.res = s1_reg.a & ~mask;
            end
            OP_DAA:
            begin
                s2_next.res = daa_res;
                s2_next.h   = 1'b0;
                s2_next.c   = daa_c;
            end
            OP_ADD16:
            begin
                s2_next.res = 8'd0;
                s2_next.wide = {hi9[7:0], s1_reg.arith.wlo[7:0]};
                s2_next.n   = 1'b0;
                s2_next.h   = hnib[4];
                s2_next.c   = hi9[8];
            end
            default:
            begin
                s2_next.res = s1_reg.a;
            end
        endcase

        // Zero comes from the byte result, the compare difference or z_fixed.
        case (s1_reg.op)
            OP_BIT, OP_SET, OP_RES, OP_ADD16:
            begin
                s2_next.z_from_byte = 1'b0;
            end
            OP_CP:
            begin
                s2_next.z_from_byte = 1'b1;
                s2_next.zbyte       = s1_reg.arith.sum9[7:0];
            end
            default:
            begin
                s2_next.z_from_byte = (s1_reg.op <= OP_DAA);
                s2_next.zbyte       = s2_next.res;
            end
        endcase
    end

    // Stage three.
    always_comb
    begin
        result_next = s2_reg.res;
        wide_next   = s2_reg.wide;
        flags_next  = {s2_reg.z_from_byte ? (s2_reg.zbyte == 8'd0) : s2_reg.z_fixed,
                       s2_reg.n, s2_reg.h, s2_reg.c};
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (adv2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (adv3 && v2_reg)
        begin
            result_reg <= result_next;
            wide_reg   <= wide_next;
            flags_reg  <= flags_next;
        end
    end

    assign out_valid   = v3_reg;
    assign result      = result_reg;
    assign wide_result = wide_reg;
    assign flags_out   = flags_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for eight_bit_alu_with_flags_core: a queue-fed driver,
// a clocked monitor and an in-bench ALU predictor, with randomised idling on both sides.
// Depends on ealu_pkg and the core RTL only.
module tb;
    import ealu_pkg::*;

    localparam logic [4:0] OP_FIRST_UNUSED = 5'd23;
    localparam logic [4:0] OP_LAST_CODE    = 5'd31;
    localparam int         LONG_HOLD       = 80;
    localparam int         RANDOM_PER_MIX  = 660;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [2:0]  bit_idx;
        logic [15:0] wa;
        logic [15:0] wb;
        logic [3:0]  flags;
    } alu_item_t;

    typedef struct packed {
        logic [7:0]  res;
        logic [15:0] wide;
        logic [3:0]  flags;
    } alu_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
    alu_item_t   on_bus    = '0;

    alu_item_t   ops_to_send[$];
    alu_result_t predicted_results[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int errors          = 0;
    int hold_left       = 0;
    bit hold_req        = 1'b0;
    bit hold_ack        = 1'b0;

    eight_bit_alu_with_flags_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (on_bus.opcode),
        .value_a    (on_bus.a),
        .value_b    (on_bus.b),
        .bit_index  (on_bus.bit_idx),
        .wide_a     (on_bus.wa),
        .wide_b     (on_bus.wb),
        .flags_in   (on_bus.flags),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result),
        .wide_result(wide_result),
        .flags_out  (flags_out)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic alu_result_t compute_alu(alu_item_t x);
        alu_result_t o;
        int          ai, bi, ah, bh, ci, sum;
        logic        cin, c;
        logic [7:0]  r;
        cin = x.flags[FLAG_C];
        ai = int'(x.a);
        bi = int'(x.b);
        ah = int'(x.a[3:0]);
        bh = int'(x.b[3:0]);
        o.res = x.a;
        o.wide = '0;
        o.flags = x.flags;
        case (x.opcode)
            OP_ADD, OP_ADC:
            begin
                ci = (x.opcode == OP_ADC) ? int'(cin) : 0;
                sum = ai + bi + ci;
                o.res = sum[7:0];
                o.flags = '0;
                o.flags[FLAG_Z] = (sum[7:0] == 8'h00);
                o.flags[FLAG_H] = (ah + bh + ci > 15);
                o.flags[FLAG_C] = (sum > 255);
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                ci = (x.opcode == OP_SBC) ? int'(cin) : 0;
                sum = ai - bi - ci;
                o.res = (x.opcode == OP_CP) ? x.a : sum[7:0];
                o.flags = '0;
                o.flags[FLAG_Z] = (sum[7:0] == 8'h00);
                o.flags[FLAG_N] = 1'b1;
                o.flags[FLAG_H] = (ah < bh + ci);
                o.flags[FLAG_C] = (ai < bi + ci);
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                if (x.opcode == OP_AND)
                    o.res = x.a & x.b;
                else if (x.opcode == OP_OR)
                    o.res = x.a | x.b;
                else
                    o.res = x.a ^ x.b;
                o.flags = '0;
                o.flags[FLAG_Z] = (o.res == 8'h00);
                o.flags[FLAG_H] = (x.opcode == OP_AND);
            end
            OP_INC, OP_DEC:
            begin
                o.res = (x.opcode == OP_INC) ? x.a + 8'h01 : x.a - 8'h01;
                o.flags = '0;
                o.flags[FLAG_Z] = (o.res == 8'h00);
                o.flags[FLAG_N] = (x.opcode == OP_DEC);
                o.flags[FLAG_H] = (x.opcode == OP_INC) ? (x.a[3:0] == 4'hF) : (x.a[3:0] == 4'h0);
                o.flags[FLAG_C] = cin;
            end
            OP_SWAP, OP_SLA, OP_SRA, OP_SRL, OP_RLC, OP_RRC, OP_RL, OP_RR:
            begin
                c = 1'b0;
                case (x.opcode)
                    OP_SWAP: o.res = {x.a[3:0], x.a[7:4]};
                    OP_SLA:  begin o.res = {x.a[6:0], 1'b0};    c = x.a[7]; end
                    OP_SRA:  begin o.res = {x.a[7], x.a[7:1]};  c = x.a[0]; end
                    OP_SRL:  begin o.res = {1'b0, x.a[7:1]};    c = x.a[0]; end
                    OP_RLC:  begin o.res = {x.a[6:0], x.a[7]};  c = x.a[7]; end
                    OP_RRC:  begin o.res = {x.a[0], x.a[7:1]};  c = x.a[0]; end
                    OP_RL:   begin o.res = {x.a[6:0], cin};     c = x.a[7]; end
                    default: begin o.res = {cin, x.a[7:1]};     c = x.a[0]; end
                endcase
                o.flags = '0;
                o.flags[FLAG_Z] = (o.res == 8'h00);
                o.flags[FLAG_C] = c;
            end
            OP_BIT:
            begin
                o.flags = '0;
                o.flags[FLAG_Z] = ~x.a[x.bit_idx];
                o.flags[FLAG_H] = 1'b1;
                o.flags[FLAG_C] = cin;
            end
            OP_SET: o.res = x.a | (8'h01 << x.bit_idx);
            OP_RES: o.res = x.a & ~(8'h01 << x.bit_idx);
            OP_DAA:
            begin
                r = x.a;
                c = cin;
                if (!x.flags[FLAG_N])
                begin
                    if (cin || x.a > 8'h99)
                    begin
                        r = r + 8'h60;
                        c = 1'b1;
                    end
                    if (x.flags[FLAG_H] || x.a[3:0] > 4'h9)
                        r = r + 8'h06;
                end
                else
                begin
                    if (cin)
                        r = r - 8'h60;
                    if (x.flags[FLAG_H])
                        r = r - 8'h06;
                end
                o.res = r;
                o.flags = '0;
                o.flags[FLAG_Z] = (r == 8'h00);
                o.flags[FLAG_N] = x.flags[FLAG_N];
                o.flags[FLAG_C] = c;
            end
            OP_ADD16:
            begin
                sum = int'(x.wa) + int'(x.wb);
                o.res = 8'h00;
                o.wide = sum[15:0];
                o.flags = '0;
                o.flags[FLAG_Z] = x.flags[FLAG_Z];
                o.flags[FLAG_H] = (int'(x.wa[11:0]) + int'(x.wb[11:0]) > 4095);
                o.flags[FLAG_C] = (sum > 65535);
            end
            default: ;
        endcase
        return o;
    endfunction

    // Driver: a new item goes out only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        alu_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(compute_alu(on_bus));
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (ops_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = ops_to_send.pop_front();
                    on_bus <= nxt;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result taken and drives the output stall.
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result %h/%h/%h with no item outstanding",
                           result, wide_result, flags_out);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    if (result !== want.res)
                    begin
                        $error("result: expected %h, got %h", want.res, result);
                        errors++;
                    end
                    if (wide_result !== want.wide)
                    begin
                        $error("wide_result: expected %h, got %h", want.wide, wide_result);
                        errors++;
                    end
                    if (flags_out !== want.flags)
                    begin
                        $error("flags_out: expected %b, got %b", want.flags, flags_out);
                        errors++;
                    end
                end
            end
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic queue_op(input logic [4:0] op, input logic [7:0] a, input logic [7:0] b,
                            input logic [2:0] bi, input logic [15:0] wa,
                            input logic [15:0] wb, input logic [3:0] f);
        alu_item_t x;
        x = '{opcode: op, a: a, b: b, bit_idx: bi, wa: wa, wb: wb, flags: f};
        ops_to_send.push_back(x);
        items_queued++;
    endtask

    // Operands lean towards the boundary values that move the flags.
    function automatic logic [7:0] random_byte();
        logic [7:0] edges[7];
        edges = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80};
        if ($urandom_range(99) < 25)
            return edges[$urandom_range(6)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] random_word();
        logic [15:0] edges[4];
        edges = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h0800};
        if ($urandom_range(99) < 20)
            return edges[$urandom_range(3)];
        return 16'($urandom_range(65535));
    endfunction

    task automatic load_random(input int count);
        logic [4:0] op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 95)
                op = 5'($urandom_range(int'(OP_ADD16)));
            else
                op = 5'($urandom_range(int'(OP_LAST_CODE), int'(OP_FIRST_UNUSED)));
            queue_op(op, random_byte(), random_byte(), 3'($urandom_range(7)),
                     random_word(), random_word(), 4'($urandom_range(15)));
        end
    endtask

    // The sender has nothing more to offer until every result is back.
    task automatic drain();
        while (items_accepted != items_queued || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_op(OP_ADD,   8'hFF, 8'h01, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_ADC,   8'h0F, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
        queue_op(OP_ADC,   8'hFF, 8'hFF, 3'd0, 16'h0000, 16'h0000, 4'b1111);
        queue_op(OP_SUB,   8'h00, 8'h01, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_SBC,   8'h10, 8'h0F, 3'd0, 16'h0000, 16'h0000, 4'b0001);
        queue_op(OP_AND,   8'h00, 8'hFF, 3'd0, 16'h0000, 16'h0000, 4'b1111);
        queue_op(OP_OR,    8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_XOR,   8'hAA, 8'hAA, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_CP,    8'h42, 8'h42, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_INC,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
        queue_op(OP_DEC,   8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1000);
        queue_op(OP_SWAP,  8'hF0, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1111);
        queue_op(OP_SLA,   8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_SRA,   8'h81, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_SRL,   8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_RLC,   8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_RRC,   8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_RL,    8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
        queue_op(OP_RR,    8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_BIT,   8'h7F, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0101);
        queue_op(OP_SET,   8'h00, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b1111);
        queue_op(OP_RES,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        // Decimal adjust after an addition and after a subtraction.
        queue_op(OP_DAA,   8'h9A, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
        queue_op(OP_DAA,   8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0111);
        queue_op(OP_ADD16, 8'hFF, 8'hFF, 3'd0, 16'hFFFF, 16'h0001, 4'b1000);
        queue_op(OP_ADD16, 8'h00, 8'h00, 3'd0, 16'h0FFF, 16'h0001, 4'b0111);
        queue_op(OP_LAST_CODE, 8'h5A, 8'hA5, 3'd3, 16'hFFFF, 16'hFFFF, 4'b1010);
        drain();

        send_idle_pct = 33;
        recv_idle_pct = 83;
        load_random(RANDOM_PER_MIX);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 33;
        load_random(RANDOM_PER_MIX);
        drain();

        // Full rate, with one long output hold-off while items keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random(RANDOM_PER_MIX);
        hold_req = ~hold_req;
        drain();

        repeat (10) @(posedge clk);
        $display("tb: %0d items accepted, %0d results checked across all operations",
                 items_accepted, results_checked);
        $display("tb: plus unused codes, under three idling mixes and one long output hold-off");
        if (errors == 0 && predicted_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #800000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
